// File: sv/txtcon_pkg.sv
// Shared types, constants and lookup functions for the text console engine.
package txtcon_pkg;

  // Parameter defaults
  localparam int MaxColumnsDef  = 80;
  localparam int MaxRowsDef     = 25;
  localparam int EscapeDepthDef = 16;
  localparam int TabWidthDef    = 4;

  // Request modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;

  // Escape parser phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_SEQ  = 2'd2;

  // Attributes and special bytes
  localparam logic [7:0] DEFAULT_ATTR = 8'h07;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_M     = 8'h6D;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  data_byte;
    logic        end_of_string;
    logic [10:0] cell_index;
  } con_in_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [7:0]  cell_color;
    logic [6:0]  out_col;
    logic [4:0]  out_row;
    logic [10:0] cursor_pos;
    logic [7:0]  current_color;
  } con_out_t;

  // ANSI color index to VGA attribute nibble
  function automatic logic [3:0] sgr_palette(input logic [3:0] idx);
    logic [3:0] p;
    unique case (idx)
      4'd0:  p = 4'h0;
      4'd1:  p = 4'h4;
      4'd2:  p = 4'h2;
      4'd3:  p = 4'h6;
      4'd4:  p = 4'h1;
      4'd5:  p = 4'h5;
      4'd6:  p = 4'h3;
      4'd7:  p = 4'h7;
      4'd8:  p = 4'h8;
      4'd9:  p = 4'hC;
      4'd10: p = 4'hA;
      4'd11: p = 4'hE;
      4'd12: p = 4'h9;
      4'd13: p = 4'hD;
      4'd14: p = 4'hB;
      default: p = 4'hF;
    endcase
    return p;
  endfunction

  // Apply one SGR code to an attribute
  function automatic logic [7:0] sgr_apply(input logic [7:0] attr, input logic [7:0] code);
    logic [7:0] a;
    a = attr;
    if (code >= 8'd30 && code < 8'd38)
      a = {attr[7:4], sgr_palette(4'(code - 8'd30))};
    else if (code >= 8'd90 && code < 8'd98)
      a = {attr[7:4], sgr_palette(4'(code - 8'd82))};
    else if (code >= 8'd40 && code < 8'd48)
      a = {sgr_palette(4'(code - 8'd40)), attr[3:0]};
    else if (code >= 8'd100 && code < 8'd108)
      a = {sgr_palette(4'(code - 8'd92)), attr[3:0]};
    else if (code == 8'd0)
      a = DEFAULT_ATTR;
    return a;
  endfunction

  // Tab pad length for every 7-bit column, built without division
  function automatic logic [128*5-1:0] pad_table(input int tab);
    logic [128*5-1:0] t;
    int m;
    t = '0;
    m = 0;
    for (int i = 0; i < 128; i++) begin
      t[i*5 +: 5] = 5'(tab - m);
      m = m + 1;
      if (m == tab) m = 0;
    end
    return t;
  endfunction

endpackage

// File: sv/text_console_with_ansi_color.sv
// Text console engine: cell store, cursor, tab/wrap/scroll and ANSI SGR color parsing.
//
//   channel | direction | payload                   | handshake
//   in_     | input     | txtcon_pkg::con_in_t      | in_valid / in_stall
//   out_    | output    | txtcon_pkg::con_out_t     | out_valid / out_stall
//   cfg_    | input     | cfg_index, cfg_data       | cfg_we
//
// One request at a time; the cell memory (one write, one read a cycle) sets the pace.
// A plain byte passes the decode, glyph, post and capture states before its result shows,
// and the next request is taken once the result has left. A tab repeats the glyph state
// for each extra pad space, an SGR sequence walks each buffered byte, and a scroll copies
// every line up and blanks the bottom one. Clear screen walks all MAX_COLUMNS*MAX_ROWS
// cells, one per cycle; the same clearing pass runs after reset, with in_stall high until
// it ends. A stalled result holds in the output register; no request is taken meanwhile.
module text_console_with_ansi_color #(
  parameter int MAX_COLUMNS  = txtcon_pkg::MaxColumnsDef,
  parameter int MAX_ROWS     = txtcon_pkg::MaxRowsDef,
  parameter int ESCAPE_DEPTH = txtcon_pkg::EscapeDepthDef,
  parameter int TAB_WIDTH    = txtcon_pkg::TabWidthDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  txtcon_pkg::con_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output txtcon_pkg::con_out_t out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [6:0]           cfg_data
);

  localparam int CellCount = MAX_COLUMNS * MAX_ROWS;
  localparam int AW = $clog2(CellCount);
  localparam int TW = $clog2(CellCount + 1);
  localparam int LW = $clog2(ESCAPE_DEPTH + 1);
  localparam int IW = $clog2(ESCAPE_DEPTH);
  localparam logic [128*5-1:0] PadTbl = txtcon_pkg::pad_table(TAB_WIDTH);

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_WB       = 4'd1;
  localparam logic [3:0] S_HI       = 4'd2;
  localparam logic [3:0] S_POST     = 4'd3;
  localparam logic [3:0] S_FLUSH    = 4'd4;
  localparam logic [3:0] S_SGR      = 4'd5;
  localparam logic [3:0] S_GLY      = 4'd6;
  localparam logic [3:0] S_SC_COPY  = 4'd7;
  localparam logic [3:0] S_SC_DRAIN = 4'd8;
  localparam logic [3:0] S_SC_CLR   = 4'd9;
  localparam logic [3:0] S_CLR      = 4'd10;
  localparam logic [3:0] S_READ     = 4'd11;
  localparam logic [3:0] S_READ2    = 4'd12;
  localparam logic [3:0] S_FIN      = 4'd13;
  localparam logic [3:0] S_OUT      = 4'd14;

  logic [3:0]    state_r, state_nxt;
  logic [6:0]    cols_r, cols_nxt;
  logic [4:0]    rows_r, rows_nxt;
  logic [6:0]    col_r, col_nxt;
  logic [4:0]    row_r, row_nxt;
  logic [7:0]    attr_r, attr_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    acc_r, acc_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          eos_r, eos_nxt;
  logic [10:0]   cidx_r, cidx_nxt;
  logic [7:0]    g_r, g_nxt;
  logic [4:0]    rep_r, rep_nxt;
  logic [3:0]    gret_r, gret_nxt;
  logic [3:0]    fret_r, fret_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic          clr_out_r, clr_out_nxt;
  logic [15:0]   cell_r, cell_nxt;
  txtcon_pkg::con_out_t out_r, out_nxt;

  // Cell memory and escape buffer
  logic [15:0]   cell_mem [CellCount];
  logic [15:0]   rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata;
  logic [7:0]    esc_buf [ESCAPE_DEPTH];
  logic [7:0]    buf_rd_r;
  logic          buf_we;
  logic [IW-1:0] buf_widx;
  logic [7:0]    buf_wdata;

  // Effective geometry
  logic [6:0]    eff_c, cfg_c;
  logic [4:0]    eff_r, cfg_r;
  logic [TW-1:0] total;
  logic [TW-1:0] lin_pos;
  logic          launch_en;
  logic [7:0]    launch_byte;
  logic [7:0]    ncol;
  logic [5:0]    nrow;
  logic          glyph_cont;

  function automatic logic [6:0] clamp_c(input logic [6:0] v);
    logic [6:0] r;
    r = v;
    if (v == 7'd0) r = 7'd1;
    else if ({1'b0, v} > 8'(MAX_COLUMNS)) r = 7'(MAX_COLUMNS);
    return r;
  endfunction

  function automatic logic [4:0] clamp_r(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (v == 5'd0) r = 5'd1;
    else if ({1'b0, v} > 6'(MAX_ROWS)) r = 5'(MAX_ROWS);
    return r;
  endfunction

  assign eff_c   = clamp_c(cols_r);
  assign eff_r   = clamp_r(rows_r);
  assign total   = TW'({5'd0, eff_c} * {7'd0, eff_r});
  assign lin_pos = TW'({7'd0, row_r} * {5'd0, eff_c} + {5'd0, col_r});

  // Memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
    rdata_r <= cell_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (buf_we) esc_buf[buf_widx] <= buf_wdata;
    buf_rd_r <= esc_buf[idx_nxt[IW-1:0]];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;  cols_nxt = cols_r;  rows_nxt = rows_r;
    col_nxt = col_r;      row_nxt = row_r;    attr_nxt = attr_r;
    phase_nxt = phase_r;  acc_nxt = acc_r;    len_nxt = len_r;
    idx_nxt = idx_r;      byte_nxt = byte_r;  eos_nxt = eos_r;
    cidx_nxt = cidx_r;    g_nxt = g_r;        rep_nxt = rep_r;
    gret_nxt = gret_r;    fret_nxt = fret_r;  ptr_nxt = ptr_r;
    pend_nxt = pend_r;    pend_addr_nxt = pend_addr_r;
    clr_out_nxt = clr_out_r; cell_nxt = cell_r; out_nxt = out_r;
    mem_we = 1'b0;  mem_waddr = ptr_r;  mem_raddr = ptr_r;
    mem_wdata = {txtcon_pkg::DEFAULT_ATTR, 8'h00};
    buf_we = 1'b0;  buf_widx = '0;  buf_wdata = byte_r;
    launch_en = 1'b0;  launch_byte = byte_r;
    ncol = {1'b0, col_r};  nrow = {1'b0, row_r};
    glyph_cont = 1'b0;
    cfg_c = eff_c;  cfg_r = eff_r;

    // Write a buffered pending copy during scroll
    if (pend_r) begin
      mem_we = 1'b1;
      mem_waddr = pend_addr_r;
      mem_wdata = rdata_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          if (cfg_index == txtcon_pkg::CFG_COLUMNS) begin
            cols_nxt = cfg_data;
            cfg_c = clamp_c(cfg_data);
          end else if (cfg_index == txtcon_pkg::CFG_ROWS) begin
            rows_nxt = cfg_data[4:0];
            cfg_r = clamp_r(cfg_data[4:0]);
          end
          if (col_r >= cfg_c) col_nxt = cfg_c - 7'd1;
          if (row_r >= cfg_r) row_nxt = cfg_r - 5'd1;
        end
        if (in_valid) begin
          byte_nxt = in_data.data_byte;
          eos_nxt  = in_data.end_of_string;
          cidx_nxt = in_data.cell_index;
          cell_nxt = '0;
          unique case (in_data.mode)
            txtcon_pkg::MODE_WRITE: state_nxt = S_WB;
            txtcon_pkg::MODE_READ:  state_nxt = S_READ;
            txtcon_pkg::MODE_CLEAR: begin
              ptr_nxt = '0;
              clr_out_nxt = 1'b1;
              state_nxt = S_CLR;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      // Decide what the byte does to the escape parser
      S_WB: begin
        if (phase_r == txtcon_pkg::PH_ESC && byte_r == txtcon_pkg::CH_LBRK &&
            len_r < LW'(ESCAPE_DEPTH)) begin
          buf_we = 1'b1;  buf_widx = len_r[IW-1:0];
          len_nxt = len_r + 1'b1;
          phase_nxt = txtcon_pkg::PH_SEQ;
          acc_nxt = '0;
          state_nxt = S_POST;
        end else if (phase_r == txtcon_pkg::PH_SEQ && byte_r == txtcon_pkg::CH_M) begin
          acc_nxt = '0;
          idx_nxt = '0;
          state_nxt = S_SGR;
        end else if (phase_r == txtcon_pkg::PH_SEQ && len_r < LW'(ESCAPE_DEPTH)) begin
          buf_we = 1'b1;  buf_widx = len_r[IW-1:0];
          len_nxt = len_r + 1'b1;
          state_nxt = S_POST;
        end else if (phase_r != txtcon_pkg::PH_IDLE) begin
          idx_nxt = '0;
          fret_nxt = S_HI;
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_HI;
        end
      end

      // Handle the byte fresh
      S_HI: begin
        if (byte_r == txtcon_pkg::CH_ESC) begin
          buf_we = 1'b1;  buf_widx = '0;
          len_nxt = LW'(1);
          phase_nxt = txtcon_pkg::PH_ESC;
          state_nxt = S_POST;
        end else begin
          launch_en = 1'b1;
          launch_byte = byte_r;
          gret_nxt = S_POST;
        end
      end

      // Flush an unfinished sequence at string end
      S_POST: begin
        if (eos_r && phase_r != txtcon_pkg::PH_IDLE) begin
          idx_nxt = '0;
          fret_nxt = S_FIN;
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_FIN;
        end
      end

      // Print buffered bytes literally
      S_FLUSH: begin
        if (idx_r < len_r) begin
          launch_en = 1'b1;
          launch_byte = buf_rd_r;
          idx_nxt = idx_r + 1'b1;
          gret_nxt = S_FLUSH;
        end else begin
          len_nxt = '0;
          phase_nxt = txtcon_pkg::PH_IDLE;
          acc_nxt = '0;
          state_nxt = fret_r;
        end
      end

      // Walk the buffer, then apply the closing code
      S_SGR: begin
        if (idx_r < len_r) begin
          idx_nxt = idx_r + 1'b1;
          if (buf_rd_r >= txtcon_pkg::CH_ZERO && buf_rd_r <= txtcon_pkg::CH_NINE) begin
            acc_nxt = 8'(acc_r * 8'd10) + 8'(buf_rd_r - txtcon_pkg::CH_ZERO);
          end else if (buf_rd_r == txtcon_pkg::CH_SEMI) begin
            attr_nxt = txtcon_pkg::sgr_apply(attr_r, acc_r);
            acc_nxt = '0;
          end
        end else begin
          attr_nxt = txtcon_pkg::sgr_apply(attr_r, acc_r);
          acc_nxt = '0;
          len_nxt = '0;
          phase_nxt = txtcon_pkg::PH_IDLE;
          state_nxt = S_POST;
        end
      end

      // Place one glyph and move the cursor
      S_GLY: begin
        if (g_r == txtcon_pkg::CH_LF) begin
          ncol = '0;
          nrow = {1'b0, row_r} + 6'd1;
        end else if (g_r == txtcon_pkg::CH_CR) begin
          ncol = '0;
        end else begin
          mem_we = 1'b1;
          mem_waddr = AW'(lin_pos);
          mem_wdata = {attr_r, g_r};
          ncol = {1'b0, col_r} + 8'd1;
        end
        if (ncol >= {1'b0, eff_c}) begin
          ncol = '0;
          nrow = nrow + 6'd1;
        end
        col_nxt = ncol[6:0];
        row_nxt = nrow[4:0];
        if (nrow >= {1'b0, eff_r}) begin
          pend_nxt = 1'b0;
          if (TW'(eff_c) >= total) begin
            ptr_nxt = '0;
            state_nxt = S_SC_CLR;
          end else begin
            ptr_nxt = AW'(eff_c);
            state_nxt = S_SC_COPY;
          end
        end else begin
          glyph_cont = 1'b1;
        end
      end

      // Move every line up by one
      S_SC_COPY: begin
        mem_raddr = ptr_r;
        pend_nxt = 1'b1;
        pend_addr_nxt = ptr_r - AW'(eff_c);
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == AW'(total - 1'b1)) state_nxt = S_SC_DRAIN;
      end

      S_SC_DRAIN: begin
        pend_nxt = 1'b0;
        ptr_nxt = AW'(total - TW'(eff_c));
        state_nxt = S_SC_CLR;
      end

      // Blank the bottom line
      S_SC_CLR: begin
        mem_we = 1'b1;
        mem_waddr = ptr_r;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == AW'(total - 1'b1)) begin
          row_nxt = row_nxt - 5'd1;
          glyph_cont = 1'b1;
        end
      end

      // Blank the whole store
      S_CLR: begin
        mem_we = 1'b1;
        mem_waddr = ptr_r;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == AW'(CellCount - 1)) begin
          col_nxt = '0;
          row_nxt = '0;
          state_nxt = clr_out_r ? S_FIN : S_IDLE;
        end
      end

      S_READ: begin
        mem_raddr = AW'(cidx_r);
        state_nxt = S_READ2;
      end

      S_READ2: begin
        if (32'(cidx_r) < 32'(total)) cell_nxt = rdata_r;
        state_nxt = S_FIN;
      end

      // Capture the result
      S_FIN: begin
        out_nxt.cell_char     = cell_r[7:0];
        out_nxt.cell_color    = cell_r[15:8];
        out_nxt.out_col       = col_r;
        out_nxt.out_row       = row_r;
        out_nxt.cursor_pos    = 11'(lin_pos);
        out_nxt.current_color = attr_r;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // Continue a tab run or return to the caller
    if (glyph_cont) begin
      if (rep_r != 5'd0) begin
        rep_nxt = rep_r - 5'd1;
        state_nxt = S_GLY;
      end else begin
        state_nxt = gret_r;
      end
    end

    // Start a glyph; tab expands to spaces
    if (launch_en) begin
      if (launch_byte == txtcon_pkg::CH_TAB) begin
        g_nxt = txtcon_pkg::CH_SPACE;
        rep_nxt = PadTbl[col_r*5 +: 5] - 5'd1;
      end else begin
        g_nxt = launch_byte;
        rep_nxt = '0;
      end
      state_nxt = S_GLY;
    end
  end

  // Hold control state; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      cols_r    <= 7'd80;
      rows_r    <= 5'd25;
      col_r     <= '0;
      row_r     <= '0;
      attr_r    <= txtcon_pkg::DEFAULT_ATTR;
      phase_r   <= txtcon_pkg::PH_IDLE;
      acc_r     <= '0;
      len_r     <= '0;
      idx_r     <= '0;
      ptr_r     <= '0;
      pend_r    <= 1'b0;
      clr_out_r <= 1'b0;
      gret_r    <= S_POST;
      fret_r    <= S_FIN;
    end else begin
      state_r   <= state_nxt;
      cols_r    <= cols_nxt;
      rows_r    <= rows_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      attr_r    <= attr_nxt;
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      len_r     <= len_nxt;
      idx_r     <= idx_nxt;
      ptr_r     <= ptr_nxt;
      pend_r    <= pend_nxt;
      clr_out_r <= clr_out_nxt;
      gret_r    <= gret_nxt;
      fret_r    <= fret_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    eos_r       <= eos_nxt;
    cidx_r      <= cidx_nxt;
    g_r         <= g_nxt;
    rep_r       <= rep_nxt;
    pend_addr_r <= pend_addr_nxt;
    cell_r      <= cell_nxt;
    out_r       <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted without entering busy");

  a_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  a_escape_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(ESCAPE_DEPTH))
    else $error("escape buffer overrun");

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> col_r < eff_c && row_r < eff_r)
    else $error("cursor outside screen when idle");
`endif

endmodule

// File: test/txtcon_checker.sv
// Console result checker: watches the request, result and register ports and predicts each result.
module txtcon_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  txtcon_pkg::con_in_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  txtcon_pkg::con_out_t out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [6:0]           cfg_data,
  output int                   fails,
  output int                   pending
);

  localparam int MaxW      = txtcon_pkg::MaxColumnsDef;
  localparam int MaxH      = txtcon_pkg::MaxRowsDef;
  localparam int CellTotal = MaxW * MaxH;
  localparam int EscDepth  = txtcon_pkg::EscapeDepthDef;
  localparam int TabStop   = txtcon_pkg::TabWidthDef;
  localparam logic [3:0] NIBBLE_MAP [16] = '{
    4'h0, 4'h4, 4'h2, 4'h6, 4'h1, 4'h5, 4'h3, 4'h7,
    4'h8, 4'hC, 4'hA, 4'hE, 4'h9, 4'hD, 4'hB, 4'hF
  };

  logic [15:0] screen [CellTotal];
  int          cur_x;
  int          cur_y;
  logic [7:0]  attr;
  logic [1:0]  phase;
  logic [7:0]  sgr_code;
  logic [7:0]  esc_buf [EscDepth];
  int          esc_len;
  int          width_reg;
  int          height_reg;
  txtcon_pkg::con_out_t expected_views [$];

  function automatic int screen_width();
    return (width_reg < 1) ? 1 : (width_reg > MaxW) ? MaxW : width_reg;
  endfunction

  function automatic int screen_height();
    return (height_reg < 1) ? 1 : (height_reg > MaxH) ? MaxH : height_reg;
  endfunction

  // Print one non-tab glyph, then wrap and scroll as needed
  task automatic advance_cell(input logic [7:0] ch);
    int w;
    int h;
    int idx;
    w = screen_width();
    h = screen_height();
    if (ch == txtcon_pkg::CH_LF) begin
      cur_x = 0;
      cur_y++;
    end else if (ch == txtcon_pkg::CH_CR) begin
      cur_x = 0;
    end else begin
      idx = cur_y * w + cur_x;
      if (idx < CellTotal) screen[idx] = {attr, ch};
      cur_x++;
    end
    if (cur_x >= w) begin
      cur_y++;
      cur_x = 0;
    end
    if (cur_y >= h) begin
      for (int i = w; i < w * h; i++) screen[i - w] = screen[i];
      for (int i = w * h - w; i < w * h; i++) screen[i] = {txtcon_pkg::DEFAULT_ATTR, 8'h00};
      if (cur_y > 0) cur_y--;
    end
  endtask

  // Tab expands to spaces up to the next stop
  task automatic place_glyph(input logic [7:0] ch);
    int n;
    if (ch == txtcon_pkg::CH_TAB) begin
      n = TabStop - (cur_x % TabStop);
      repeat (n) advance_cell(txtcon_pkg::CH_SPACE);
    end else begin
      advance_cell(ch);
    end
  endtask

  task automatic apply_sgr(input logic [7:0] code);
    if (code >= 30 && code < 38)
      attr = {attr[7:4], NIBBLE_MAP[code - 30]};
    else if (code >= 90 && code < 98)
      attr = {attr[7:4], NIBBLE_MAP[code - 90 + 8]};
    else if (code >= 40 && code < 48)
      attr = {NIBBLE_MAP[code - 40], attr[3:0]};
    else if (code >= 100 && code < 108)
      attr = {NIBBLE_MAP[code - 100 + 8], attr[3:0]};
    else if (code == 0)
      attr = txtcon_pkg::DEFAULT_ATTR;
  endtask

  task automatic feed_sgr(input logic [7:0] b);
    if (b >= txtcon_pkg::CH_ZERO && b <= txtcon_pkg::CH_NINE) begin
      sgr_code = 8'(sgr_code * 8'd10 + (b - txtcon_pkg::CH_ZERO));
    end else if (b == txtcon_pkg::CH_SEMI || b == txtcon_pkg::CH_M) begin
      apply_sgr(sgr_code);
      sgr_code = 8'h00;
    end
  endtask

  // Print the buffered escape bytes literally and drop back to idle
  task automatic flush_escape();
    for (int i = 0; i < esc_len && i < EscDepth; i++) place_glyph(esc_buf[i]);
    esc_len = 0;
    phase = txtcon_pkg::PH_IDLE;
    sgr_code = 8'h00;
  endtask

  task automatic start_byte(input logic [7:0] b);
    if (b == txtcon_pkg::CH_ESC) begin
      esc_buf[0] = b;
      esc_len = 1;
      phase = txtcon_pkg::PH_ESC;
    end else begin
      place_glyph(b);
    end
  endtask

  task automatic write_byte(input logic [7:0] b);
    if (phase == txtcon_pkg::PH_ESC) begin
      if (b == txtcon_pkg::CH_LBRK && esc_len < EscDepth) begin
        esc_buf[esc_len] = b;
        esc_len++;
        phase = txtcon_pkg::PH_SEQ;
        sgr_code = 8'h00;
      end else begin
        flush_escape();
        start_byte(b);
      end
    end else if (phase == txtcon_pkg::PH_SEQ) begin
      if (b == txtcon_pkg::CH_M) begin
        sgr_code = 8'h00;
        for (int i = 0; i < esc_len && i < EscDepth; i++) feed_sgr(esc_buf[i]);
        feed_sgr(b);
        esc_len = 0;
        phase = txtcon_pkg::PH_IDLE;
        sgr_code = 8'h00;
      end else if (esc_len < EscDepth) begin
        esc_buf[esc_len] = b;
        esc_len++;
      end else begin
        flush_escape();
        start_byte(b);
      end
    end else begin
      phase = txtcon_pkg::PH_IDLE;
      start_byte(b);
    end
  endtask

  task automatic predict_view(input txtcon_pkg::con_in_t req,
                              output txtcon_pkg::con_out_t view);
    int w;
    view = '0;
    if (req.mode == txtcon_pkg::MODE_WRITE) begin
      write_byte(req.data_byte);
      if (req.end_of_string && phase != txtcon_pkg::PH_IDLE) flush_escape();
    end else if (req.mode == txtcon_pkg::MODE_READ) begin
      if (req.cell_index < screen_width() * screen_height()) begin
        view.cell_char  = screen[req.cell_index][7:0];
        view.cell_color = screen[req.cell_index][15:8];
      end
    end else if (req.mode == txtcon_pkg::MODE_CLEAR) begin
      for (int i = 0; i < CellTotal; i++) screen[i] = {txtcon_pkg::DEFAULT_ATTR, 8'h00};
      cur_x = 0;
      cur_y = 0;
    end
    w = screen_width();
    view.out_col       = 7'(cur_x);
    view.out_row       = 5'(cur_y);
    view.cursor_pos    = 11'(cur_y * w + cur_x);
    view.current_color = attr;
  endtask

  task automatic report(input string field, input int want, input int got);
    fails++;
    if (fails <= 10) $display("mismatch in %s: expected %0h, got %0h", field, want, got);
  endtask

  always @(posedge clk) begin
    txtcon_pkg::con_out_t want;
    txtcon_pkg::con_out_t next_view;
    if (!rst_n) begin
      for (int i = 0; i < CellTotal; i++) screen[i] = {txtcon_pkg::DEFAULT_ATTR, 8'h00};
      cur_x = 0;
      cur_y = 0;
      attr = txtcon_pkg::DEFAULT_ATTR;
      phase = txtcon_pkg::PH_IDLE;
      sgr_code = 8'h00;
      esc_len = 0;
      width_reg = 80;
      height_reg = 25;
      expected_views.delete();
      fails = 0;
    end else begin
      // Compare the result leaving the block this cycle
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          fails++;
          if (fails <= 10) $display("result with no request outstanding");
        end else begin
          want = expected_views.pop_front();
          if (out_data.cell_char != want.cell_char)
            report("cell_char", want.cell_char, out_data.cell_char);
          if (out_data.cell_color != want.cell_color)
            report("cell_color", want.cell_color, out_data.cell_color);
          if (out_data.out_col != want.out_col)
            report("out_col", want.out_col, out_data.out_col);
          if (out_data.out_row != want.out_row)
            report("out_row", want.out_row, out_data.out_row);
          if (out_data.cursor_pos != want.cursor_pos)
            report("cursor_pos", want.cursor_pos, out_data.cursor_pos);
          if (out_data.current_color != want.current_color)
            report("current_color", want.current_color, out_data.current_color);
        end
      end
      // Register writes: keep cells, clamp the cursor into the new screen
      if (cfg_we) begin
        if (cfg_index == txtcon_pkg::CFG_COLUMNS) width_reg = cfg_data;
        else if (cfg_index == txtcon_pkg::CFG_ROWS) height_reg = cfg_data & 7'h1F;
        if (cur_x >= screen_width()) cur_x = screen_width() - 1;
        if (cur_y >= screen_height()) cur_y = screen_height() - 1;
      end
      if (in_valid && !in_stall) begin
        predict_view(in_data, next_view);
        expected_views.push_back(next_view);
      end
    end
    pending <= expected_views.size();
  end

endmodule

// File: test/tb.sv
// Top of the console testbench: clock, reset, request and register stimulus, verdict.
module tb;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam longint CycleLimit = 4000000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  txtcon_pkg::con_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  txtcon_pkg::con_out_t out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = txtcon_pkg::CFG_COLUMNS;
  logic [6:0] cfg_data = '0;
  int         fails;
  int         pending;
  bit         calm = 1'b1;
  int         stall_left = 0;
  longint     cycles = 0;
  int         sent = 0;
  int         width_now = 80;
  int         height_now = 25;

  text_console_with_ansi_color uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  txtcon_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up on a hung block
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic txtcon_pkg::con_in_t byte_req(input logic [7:0] b, input bit eos);
    txtcon_pkg::con_in_t r;
    r = '{mode: txtcon_pkg::MODE_WRITE, data_byte: b, end_of_string: eos,
          cell_index: 11'($urandom_range(0, 2047))};
    return r;
  endfunction

  function automatic txtcon_pkg::con_in_t mode_req(input logic [1:0] m, input int idx);
    txtcon_pkg::con_in_t r;
    r = '{mode: m, data_byte: 8'($urandom_range(0, 255)),
          end_of_string: 1'($urandom_range(0, 1)), cell_index: 11'(idx)};
    return r;
  endfunction

  // Offer one request and hold it until it is taken
  task automatic send(input txtcon_pkg::con_in_t req);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_text(input string s, input bit eos);
    for (int i = 0; i < s.len(); i++) send(byte_req(s[i], eos && i == s.len() - 1));
  endtask

  // Hold off until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_geometry(input int w, input int h);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= txtcon_pkg::CFG_COLUMNS;
    cfg_data <= 7'(w);
    @(posedge clk);
    cfg_index <= txtcon_pkg::CFG_ROWS;
    cfg_data <= 7'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    width_now = (w < 1) ? 1 : (w > 80) ? 80 : w;
    height_now = ((h & 31) < 1) ? 1 : ((h & 31) > 25) ? 25 : (h & 31);
  endtask

  function automatic int sgr_pick();
    int k;
    k = $urandom_range(0, 5);
    case (k)
      0: return 0;
      1: return $urandom_range(30, 37);
      2: return $urandom_range(40, 47);
      3: return $urandom_range(90, 97);
      4: return $urandom_range(100, 107);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // One random chunk: mostly well-formed text and color sequences
  task automatic random_chunk();
    int    pick;
    int    n;
    string seq;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
        send(byte_req(8'($urandom_range(32, 126)), i == n - 1 && $urandom_range(0, 1)));
    end else if (pick < 55) begin
      seq = "\033[";
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        if (i > 0) seq = {seq, ";"};
        if ($urandom_range(0, 9) == 0) seq = {seq, "x"};
        seq = {seq, $sformatf("%0d", sgr_pick())};
      end
      send_text({seq, "m"}, 1'($urandom_range(0, 1)));
    end else if (pick < 65) begin
      n = $urandom_range(0, 2);
      send(byte_req(n == 0 ? txtcon_pkg::CH_LF :
                    n == 1 ? txtcon_pkg::CH_CR : txtcon_pkg::CH_TAB, 1'b0));
      send(byte_req(8'($urandom_range(32, 126)), 1'b0));
    end else if (pick < 75) begin
      if ($urandom_range(0, 1))
        send(mode_req(txtcon_pkg::MODE_READ, $urandom_range(0, width_now * height_now - 1)));
      else
        send(mode_req(txtcon_pkg::MODE_READ, $urandom_range(0, 2047)));
    end else if (pick < 77) begin
      send(mode_req(txtcon_pkg::MODE_CLEAR, $urandom_range(0, 2047)));
    end else if (pick < 79) begin
      send(mode_req(MODE_SPARE, $urandom_range(0, 2047)));
    end else if (pick < 87) begin
      send(byte_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    end else if (pick < 93) begin
      // Cut short: string end inside a sequence, or ESC not followed by '['
      if ($urandom_range(0, 1)) begin
        send_text($sformatf("\033[%0d", $urandom_range(0, 199)), 1'b1);
      end else begin
        send(byte_req(txtcon_pkg::CH_ESC, 1'b0));
        send(byte_req(8'($urandom_range(32, 90)), 1'($urandom_range(0, 1))));
      end
    end else begin
      // Fill or overflow the escape buffer
      send(byte_req(txtcon_pkg::CH_ESC, 1'b0));
      send(byte_req(txtcon_pkg::CH_LBRK, 1'b0));
      n = $urandom_range(14, 17);
      for (int i = 0; i < n; i++)
        send(byte_req($urandom_range(0, 3) == 0 ? txtcon_pkg::CH_SEMI :
                      8'($urandom_range(48, 57)), 1'b0));
      send(byte_req(txtcon_pkg::CH_M, 1'b0));
    end
  endtask

  task automatic random_phase(input int count, input bit quiet);
    int target;
    calm = quiet;
    target = sent + count;
    while (sent < target) random_chunk();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, controls, color sequences and cut-short escapes
    calm = 1'b0;
    send(mode_req(txtcon_pkg::MODE_READ, 0));
    send(byte_req(8'h00, 1'b0));
    send(byte_req(8'hFF, 1'b0));
    send(byte_req(txtcon_pkg::CH_TAB, 1'b0));
    send_text("\033[31;44m", 1'b0);
    send_text("A\033[97;107mB", 1'b0);
    send_text("\033[300m", 1'b0);
    send_text("\033[0m\r\n", 1'b0);
    send_text("\033Q", 1'b0);
    send(byte_req(txtcon_pkg::CH_ESC, 1'b1));
    send_text("\033[3", 1'b1);
    send(mode_req(txtcon_pkg::MODE_READ, 1));
    send(mode_req(txtcon_pkg::MODE_READ, 2047));
    send(mode_req(MODE_SPARE, 2047));
    send(mode_req(txtcon_pkg::MODE_CLEAR, 0));

    // Random phases over several geometries, extremes included
    random_phase(90, 1'b0);
    drain();
    random_phase(40, 1'b0);
    set_geometry(1, 1);
    random_phase(60, 1'b1);
    set_geometry(0, 0);
    random_phase(40, 1'b0);
    set_geometry(8, 3);
    random_phase(150, 1'b0);
    set_geometry(127, 127);
    random_phase(60, 1'b0);
    set_geometry(13, 4);
    random_phase(150, 1'b0);
    set_geometry(80, 25);
    random_phase(100, 1'b0);
    set_geometry(20, 6);
    random_phase(120, 1'b1);

    // Wait for the last results, then give the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
